@@ rtl/hpack_dynamic_table_unit_assert.svh @@
// Assertion macros shared by the dynamic table RTL
`ifndef HPACK_DYNAMIC_TABLE_UNIT_ASSERT_SVH
`define HPACK_DYNAMIC_TABLE_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle
`define HPK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hpack dynamic table: same-cycle check failed");

// Condition implies consequence in the next cycle
`define HPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hpack dynamic table: next-cycle check failed");

`endif

@@ rtl/hpk_pkg.sv @@
`default_nettype none
package hpk_pkg;

    localparam int RING_BYTES_DEF  = 4096;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ENTRY_OVERHEAD  = 32;
    localparam int CFG_W           = 13;
    localparam int OUT_LEN_W       = 13;
    localparam int OUT_CNT_W       = 7;
    // wide enough for name + value + overhead + current size
    localparam int ESZ_W           = 19;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_BYTE  = 2'd1,
        OP_SIZE  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_SEQUENCE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EVICT_CHK,
        S_EVICT_UPD,
        S_RD_DESC,
        S_RD_BYTE
    } t_state;

    typedef struct packed {
        t_op          op;
        logic [15:0]  name_length;
        logic [15:0]  value_length;
        logic [7:0]   data_byte;
        logic [31:0]  new_max_size;
        logic [15:0]  entry_index;
        logic [12:0]  byte_offset;
    } t_req;

    typedef struct packed {
        t_status      status;
        logic [7:0]   read_byte;
        logic [12:0]  entry_name_length;
        logic [12:0]  entry_value_length;
        logic [6:0]   live_entries;
        logic [12:0]  size_in_use;
        logic [12:0]  size_limit;
        logic         entry_committed;
    } t_rsp;

endpackage
`default_nettype wire

@@ rtl/hpk_ram.sv @@
`default_nettype none
module hpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/hpk_ctrl.sv @@
`default_nettype none
module hpk_ctrl #(
    parameter int RING_BYTES  = hpk_pkg::RING_BYTES_DEF,
    parameter int MAX_ENTRIES = hpk_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire hpk_pkg::t_req          i_req,
    output      logic                   busy,
    output      logic                   o_done,
    output      hpk_pkg::t_rsp          o_rsp,
    input  wire logic                   i_cfg_we,
    input  wire logic [hpk_pkg::CFG_W-1:0] i_cfg_data,
    // descriptor memory
    output      logic                             o_desc_we,
    output      logic [$clog2(MAX_ENTRIES)-1:0]   o_desc_waddr,
    output      logic [$clog2(RING_BYTES)+2*$clog2(RING_BYTES+1)-1:0] o_desc_wdata,
    output      logic [$clog2(MAX_ENTRIES)-1:0]   o_desc_raddr,
    input  wire logic [$clog2(RING_BYTES)+2*$clog2(RING_BYTES+1)-1:0] i_desc_rdata,
    // byte ring memory
    output      logic                             o_ring_we,
    output      logic [$clog2(RING_BYTES)-1:0]    o_ring_waddr,
    output      logic [7:0]                       o_ring_wdata,
    output      logic [$clog2(RING_BYTES)-1:0]    o_ring_raddr,
    input  wire logic [7:0]                       i_ring_rdata
);
    import hpk_pkg::*;
    `include "hpack_dynamic_table_unit_assert.svh"

    localparam int RING_AW = $clog2(RING_BYTES);
    localparam int DESC_AW = $clog2(MAX_ENTRIES);
    localparam int LEN_W   = $clog2(RING_BYTES + 1);
    localparam int SZ_W    = LEN_W;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int SL_W    = CNT_W + 1;
    localparam int RS_W    = RING_AW + 1;
    localparam int WSZ_W   = SZ_W + 2;

    function automatic logic [SZ_W-1:0] cfg_limit(input logic [CFG_W-1:0] cfg);
        logic [SZ_W-1:0] lim;
        if (cfg == '0 || 32'(cfg) > 32'(RING_BYTES)) begin
            lim = SZ_W'(RING_BYTES);
        end else begin
            lim = SZ_W'(cfg);
        end
        return lim;
    endfunction

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [DESC_AW-1:0] r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [RING_AW-1:0] r_tail, n_tail;
    logic [SZ_W-1:0]    r_used, n_used;
    logic [SZ_W-1:0]    r_acc, n_acc;
    logic [SZ_W-1:0]    r_limit, n_limit;
    logic [LEN_W-1:0]   r_pend, n_pend;
    logic [RING_AW-1:0] r_wp, n_wp;
    logic [LEN_W-1:0]   r_pn, n_pn;
    logic [LEN_W-1:0]   r_pv, n_pv;
    logic               r_done, n_done;
    t_status            r_status, n_status;
    logic [7:0]         r_rbyte, n_rbyte;
    logic [LEN_W-1:0]   r_rn, n_rn;
    logic [LEN_W-1:0]   r_rv, n_rv;
    logic               r_commit, n_commit;

    // descriptor read data fields
    logic [RING_AW-1:0] rd_start;
    logic [LEN_W-1:0]   rd_n, rd_v;
    assign {rd_start, rd_n, rd_v} = i_desc_rdata;

    // slot arithmetic
    logic [SL_W-1:0]    oldest_sum, rslot_sum;
    logic [DESC_AW-1:0] oldest_slot, read_slot;
    logic [ESZ_W-1:0]   esize;
    logic               evict_need;
    logic [LEN_W:0]     ev_bytes;
    logic [RS_W-1:0]    ev_tail_sum, wp_sum, rd_addr_sum;
    logic [WSZ_W-1:0]   com_bytes;

    always_comb begin
        oldest_sum  = SL_W'(r_head) + SL_W'(MAX_ENTRIES) - SL_W'(r_count);
        oldest_slot = (oldest_sum >= SL_W'(MAX_ENTRIES))
                    ? DESC_AW'(oldest_sum - SL_W'(MAX_ENTRIES)) : DESC_AW'(oldest_sum);
        rslot_sum   = SL_W'(r_head) + SL_W'(MAX_ENTRIES) - SL_W'(r_req.entry_index);
        read_slot   = (rslot_sum >= SL_W'(MAX_ENTRIES))
                    ? DESC_AW'(rslot_sum - SL_W'(MAX_ENTRIES)) : DESC_AW'(rslot_sum);
        esize       = ESZ_W'(r_req.name_length) + ESZ_W'(r_req.value_length)
                    + ESZ_W'(ENTRY_OVERHEAD);
        if (r_req.op == OP_BEGIN) begin
            evict_need = ((ESZ_W'(r_acc) + esize > ESZ_W'(r_limit))
                         || r_count >= CNT_W'(MAX_ENTRIES)) && r_count != '0;
        end else begin
            evict_need = (r_acc > r_limit) && r_count != '0;
        end
        ev_bytes    = (LEN_W+1)'(rd_n) + (LEN_W+1)'(rd_v);
        ev_tail_sum = RS_W'(r_tail) + RS_W'(ev_bytes);
        wp_sum      = RS_W'(r_tail) + RS_W'(r_used);
        rd_addr_sum = RS_W'(rd_start) + RS_W'(r_req.byte_offset);
        com_bytes   = WSZ_W'(r_pn) + WSZ_W'(r_pv);
    end

    // next state, table update and memory control
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_head   = r_head;
        n_count  = r_count;
        n_tail   = r_tail;
        n_used   = r_used;
        n_acc    = r_acc;
        n_limit  = r_limit;
        n_pend   = r_pend;
        n_wp     = r_wp;
        n_pn     = r_pn;
        n_pv     = r_pv;
        n_done   = 1'b0;
        n_status = r_status;
        n_rbyte  = r_rbyte;
        n_rn     = r_rn;
        n_rv     = r_rv;
        n_commit = r_commit;

        o_desc_we    = 1'b0;
        o_desc_waddr = r_head;
        o_desc_wdata = {(wp_sum >= RS_W'(RING_BYTES)) ? RING_AW'(wp_sum - RS_W'(RING_BYTES))
                                                      : RING_AW'(wp_sum),
                        LEN_W'(r_req.name_length), LEN_W'(r_req.value_length)};
        o_desc_raddr = oldest_slot;
        o_ring_we    = 1'b0;
        o_ring_waddr = r_wp;
        o_ring_wdata = r_req.data_byte;
        o_ring_raddr = (rd_addr_sum >= RS_W'(RING_BYTES))
                     ? RING_AW'(rd_addr_sum - RS_W'(RING_BYTES)) : RING_AW'(rd_addr_sum);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status = ST_OK;
                n_rbyte  = '0;
                n_rn     = '0;
                n_rv     = '0;
                n_commit = 1'b0;
                unique case (r_req.op)
                    OP_BEGIN: begin
                        if (r_pend != '0) begin
                            n_status = ST_SEQUENCE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else if (esize > ESZ_W'(r_limit)) begin
                            // entry can never fit: drop the whole table
                            n_count  = '0;
                            n_acc    = '0;
                            n_used   = '0;
                            n_tail   = '0;
                            n_head   = '0;
                            n_status = ST_TOO_LARGE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_EVICT_CHK;
                        end
                    end
                    OP_BYTE: begin
                        if (r_pend == '0) begin
                            n_status = ST_SEQUENCE;
                        end else begin
                            o_ring_we = 1'b1;
                            n_wp = (32'(r_wp) + 1 >= RING_BYTES) ? '0 : r_wp + 1'b1;
                            n_pend = r_pend - 1'b1;
                            if (r_pend == LEN_W'(1)) begin
                                n_used   = SZ_W'(WSZ_W'(r_used) + com_bytes);
                                n_acc    = SZ_W'(WSZ_W'(r_acc) + com_bytes
                                               + WSZ_W'(ENTRY_OVERHEAD));
                                n_head   = (32'(r_head) + 1 >= MAX_ENTRIES) ? '0
                                                                            : r_head + 1'b1;
                                n_count  = r_count + 1'b1;
                                n_commit = 1'b1;
                            end
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_SIZE: begin
                        if (r_pend != '0) begin
                            n_status = ST_SEQUENCE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_limit = (r_req.new_max_size > 32'(RING_BYTES))
                                    ? SZ_W'(RING_BYTES) : SZ_W'(r_req.new_max_size);
                            n_state = S_EVICT_CHK;
                        end
                    end
                    OP_READ: begin
                        if (r_req.entry_index == '0
                            || 32'(r_req.entry_index) > 32'(r_count)) begin
                            n_status = ST_BAD_INDEX;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_desc_raddr = read_slot;
                            n_state      = S_RD_DESC;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EVICT_CHK: begin
                if (evict_need) begin
                    o_desc_raddr = oldest_slot;
                    n_state      = S_EVICT_UPD;
                end else begin
                    if (r_req.op == OP_BEGIN) begin
                        // place the descriptor and start taking bytes
                        o_desc_we = 1'b1;
                        n_wp   = o_desc_wdata[2*LEN_W +: RING_AW];
                        n_pn   = LEN_W'(r_req.name_length);
                        n_pv   = LEN_W'(r_req.value_length);
                        n_pend = LEN_W'(r_req.name_length) + LEN_W'(r_req.value_length);
                        if (r_req.name_length == '0 && r_req.value_length == '0) begin
                            n_acc    = r_acc + SZ_W'(ENTRY_OVERHEAD);
                            n_head   = (32'(r_head) + 1 >= MAX_ENTRIES) ? '0
                                                                        : r_head + 1'b1;
                            n_count  = r_count + 1'b1;
                            n_commit = 1'b1;
                        end
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EVICT_UPD: begin
                // drop the oldest entry
                n_tail  = (ev_tail_sum >= RS_W'(RING_BYTES))
                        ? RING_AW'(ev_tail_sum - RS_W'(RING_BYTES)) : RING_AW'(ev_tail_sum);
                n_used  = (WSZ_W'(ev_bytes) > WSZ_W'(r_used)) ? '0
                        : SZ_W'(WSZ_W'(r_used) - WSZ_W'(ev_bytes));
                n_acc   = (WSZ_W'(ev_bytes) + WSZ_W'(ENTRY_OVERHEAD) > WSZ_W'(r_acc)) ? '0
                        : SZ_W'(WSZ_W'(r_acc) - WSZ_W'(ev_bytes) - WSZ_W'(ENTRY_OVERHEAD));
                n_count = r_count - 1'b1;
                n_state = S_EVICT_CHK;
            end
            S_RD_DESC: begin
                n_rn = rd_n;
                n_rv = rd_v;
                if (32'(r_req.byte_offset) >= 32'(rd_n) + 32'(rd_v)) begin
                    n_status = ST_BAD_INDEX;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RD_BYTE;
                end
            end
            S_RD_BYTE: begin
                n_rbyte = i_ring_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // a configuration write re-initializes the table
        if (i_cfg_we) begin
            n_head  = '0;
            n_count = '0;
            n_tail  = '0;
            n_used  = '0;
            n_acc   = '0;
            n_pend  = '0;
            n_wp    = '0;
            n_limit = cfg_limit(i_cfg_data);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_tail  <= '0;
            r_used  <= '0;
            r_acc   <= '0;
            r_limit <= cfg_limit(CFG_RESET);
            r_pend  <= '0;
            r_wp    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_tail  <= n_tail;
            r_used  <= n_used;
            r_acc   <= n_acc;
            r_limit <= n_limit;
            r_pend  <= n_pend;
            r_wp    <= n_wp;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_pn     <= n_pn;
        r_pv     <= n_pv;
        r_status <= n_status;
        r_rbyte  <= n_rbyte;
        r_rn     <= n_rn;
        r_rv     <= n_rv;
        r_commit <= n_commit;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    always_comb begin
        o_rsp.status             = r_status;
        o_rsp.read_byte          = r_rbyte;
        o_rsp.entry_name_length  = OUT_LEN_W'(r_rn);
        o_rsp.entry_value_length = OUT_LEN_W'(r_rv);
        o_rsp.live_entries       = OUT_CNT_W'(r_count);
        o_rsp.size_in_use        = OUT_LEN_W'(r_acc);
        o_rsp.size_limit         = OUT_LEN_W'(r_limit);
        o_rsp.entry_committed    = r_commit;
    end

    `HPK_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy && !i_cfg_we, busy)
    `HPK_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `HPK_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ENTRIES))
    `HPK_ASSERT_NOW(a_idle_fits, i_clk, i_rst_n, r_state == S_IDLE, r_acc <= r_limit)
    `HPK_ASSERT_NOW(a_pend_room, i_clk, i_rst_n, r_pend != '0,
                    r_count < CNT_W'(MAX_ENTRIES))
endmodule
`default_nettype wire

@@ rtl/hpack_dynamic_table_unit.sv @@
`default_nettype none
// HPACK dynamic table: header entries in a byte ring, oldest evicted first.
// Requests: raise start with i_req valid; a request is taken at a clock edge
// where start is high and busy is low. Each request gives exactly one result
// on o_rsp, marked by o_done for one cycle; the receiver cannot stall.
// Steps from accept until busy is low again:
//   insert byte, and any request rejected at dispatch: dispatch only
//   begin insert, size update: dispatch, then per evicted entry a descriptor
//     memory read and an update of ring tail and sizes, then the final check
//   read byte: dispatch, descriptor memory read, then byte ring read
//   read with an offset past the entry: rejected after the descriptor read
// The result strobes in the first cycle in which busy is low again.
// Configuration: i_cfg_we with i_cfg_data sets the initial size limit and
// empties the table; write it only while busy is low and nothing is due.
// Reset empties the table and sets the limit to min(4096, ring size). Ring and
// descriptor memories are not cleared; entries are read only after writing.
module hpack_dynamic_table_unit #(
    parameter int RING_BYTES  = hpk_pkg::RING_BYTES_DEF,
    parameter int MAX_ENTRIES = hpk_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire hpk_pkg::t_req             i_req,
    output      logic                      busy,
    output      logic                      o_done,
    output      hpk_pkg::t_rsp             o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [hpk_pkg::CFG_W-1:0] i_cfg_data
);
    import hpk_pkg::*;

    localparam int RING_AW = $clog2(RING_BYTES);
    localparam int DESC_AW = $clog2(MAX_ENTRIES);
    localparam int LEN_W   = $clog2(RING_BYTES + 1);
    localparam int DESC_W  = RING_AW + 2 * LEN_W;

    logic               desc_we;
    logic [DESC_AW-1:0] desc_waddr, desc_raddr;
    logic [DESC_W-1:0]  desc_wdata, desc_rdata;
    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr, ring_raddr;
    logic [7:0]         ring_wdata, ring_rdata;

    // sequencer
    hpk_ctrl #(
        .RING_BYTES  (RING_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .busy         (busy),
        .o_done       (o_done),
        .o_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_desc_we    (desc_we),
        .o_desc_waddr (desc_waddr),
        .o_desc_wdata (desc_wdata),
        .o_desc_raddr (desc_raddr),
        .i_desc_rdata (desc_rdata),
        .o_ring_we    (ring_we),
        .o_ring_waddr (ring_waddr),
        .o_ring_wdata (ring_wdata),
        .o_ring_raddr (ring_raddr),
        .i_ring_rdata (ring_rdata)
    );

    // descriptor ring: start, name length, value length
    hpk_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_ENTRIES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (desc_waddr),
        .i_wdata (desc_wdata),
        .i_raddr (desc_raddr),
        .o_rdata (desc_rdata)
    );

    // entry byte ring
    hpk_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );
endmodule
`default_nettype wire
